// ===== rtl/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants for the multitap feedback delay: register
// indexes, reset values, arithmetic widths and the multiplier control word.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 16;
    localparam int CFG_W          = 17;
    localparam int NUM_REGS       = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_TAPS       = 4;
    localparam int TAP_IDX_W      = 2;
    localparam int SM_W           = 36;
    localparam int LP_W           = 32;
    localparam int OPA_W          = 18;
    localparam int OPB_W          = 22;
    localparam int PROD_W         = 40;
    localparam int WIDE_W         = 42;

    localparam logic [CFG_W-1:0] COEF_ONE = CFG_W'(1) << COEF_FRAC_BITS;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;
    typedef logic [CFG_W-1:0]     t_cfg_word;

    // register map
    localparam t_reg_idx REG_TAP1     = 3'd0;
    localparam t_reg_idx REG_TAP2     = 3'd1;
    localparam t_reg_idx REG_TAP3     = 3'd2;
    localparam t_reg_idx REG_TAP4     = 3'd3;
    localparam t_reg_idx REG_FEEDBACK = 3'd4;
    localparam t_reg_idx REG_LOWPASS  = 3'd5;
    localparam t_reg_idx REG_SMOOTH   = 3'd6;
    localparam t_reg_idx REG_WET      = 3'd7;

    localparam t_cfg_word CFG_RESET [NUM_REGS] = '{
        17'd0, 17'd0, 17'd0, 17'd0, 17'd6554, 17'd32768, 17'd171, 17'd32768
    };

    // accumulator actions of the shared multiplier
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADDLO
    } t_acc_op;

    typedef struct packed {
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
        t_acc_op                 op;
    } t_mac_ctl;

endpackage

// ===== rtl/mfd_ram.sv =====
// ----------------------------------------------------------------------------
// mfd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mfd_mac.sv =====
// ----------------------------------------------------------------------------
// mfd_mac
// Shared multiplier with registered product and an accumulator that builds
// floor(a * s / 2^16) from a high-part and a low-part product.
// ----------------------------------------------------------------------------
module mfd_mac (
    input  logic                              i_clk,
    input  mfd_pkg::t_mac_ctl                 i_ctl,
    output logic signed [mfd_pkg::PROD_W-1:0] o_prod,
    output logic signed [mfd_pkg::PROD_W-1:0] o_acc
);
    import mfd_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'($signed(i_ctl.a)) * PROD_W'($signed(i_ctl.b));
    end

    // accumulator: load high part, then add floored low part
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            ACC_LOAD:  r_acc <= r_prod;
            ACC_ADDLO: r_acc <= r_acc + (r_prod >>> COEF_FRAC_BITS);
            default:   r_acc <= r_acc;
        endcase
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ===== rtl/multitap_feedback_delay.sv =====
// ----------------------------------------------------------------------------
// multitap_feedback_delay
// Four-tap delay line with smoothed tap delays, lowpass-filtered feedback
// and dry/wet mix, built around one delay RAM and one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | payload
//  cfg     | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready      | i_in_sample
//  out     | out       | o_out_valid / i_out_ready    | o_out_sample
//
// For each item a sequencer walks each tap in turn, then the lowpass, the
// feedback write and the mix over the shared multiplier. An input beat is taken
// only in the idle state, so a new item waits until the last one is through.
// After reset the delay RAM is zeroed, one entry a cycle, over all BUFFER_DEPTH
// entries; no input beat is taken until then, config writes always are.
// A result waits in the output register while the next item is taken; the
// final step holds only if that register is still full and not being taken.
// ----------------------------------------------------------------------------
module multitap_feedback_delay #(
    parameter int BUFFER_DEPTH = 131072
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [mfd_pkg::CFG_W-1:0]               i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [mfd_pkg::SAMPLE_WIDTH-1:0] i_in_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [mfd_pkg::SAMPLE_WIDTH-1:0] o_out_sample
);
    import mfd_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_T_MULD, S_T_DF, S_T_Q, S_T_R, S_T_ADD, S_T_UPD,
        S_L_Q, S_L_R, S_L_ADD, S_L_YF,
        S_L2_Q, S_L2_R, S_L2_ADD, S_L_UPD,
        S_F_Q, S_F_R, S_F_ADD, S_F_WR,
        S_O_Q, S_O_R, S_O_ADD,
        S_O2_Q, S_O2_R, S_O2_ADD, S_O_OUT
    } t_state;

    t_state                      r_state;
    t_cfg_word                   r_cfg [NUM_REGS];
    logic [AW-1:0]               r_clr_addr;
    logic [AW-1:0]               r_wp;
    logic [TAP_IDX_W-1:0]        r_tap;
    logic signed [SM_W-1:0]      r_sm [NUM_TAPS];
    logic signed [LP_W-1:0]      r_lp;
    logic signed [SAMPLE_WIDTH+1:0] r_xw;
    logic signed [SAMPLE_WIDTH+2:0] r_sum;
    logic signed [34:0]          r_csd;
    logic signed [36:0]          r_df;
    logic signed [27:0]          r_m1;
    logic signed [33:0]          r_yf;
    logic signed [PROD_W-1:0]    r_od;
    logic                        r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;

    t_mac_ctl                    mac_ctl;
    logic signed [PROD_W-1:0]    mac_prod;
    logic signed [PROD_W-1:0]    mac_acc;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [SAMPLE_WIDTH-1:0]     ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [SAMPLE_WIDTH-1:0]     ram_rdata;

    logic [CFG_W-1:0]            cs, cl, fb, wet, dry, d_cur;
    logic signed [OPA_W-1:0]     as_s, al_s;
    logic signed [18:0]          as_w, al_w;
    logic signed [36:0]          n_df;
    logic signed [SAMPLE_WIDTH-1:0] n_w;
    logic signed [SAMPLE_WIDTH-1:0] n_out;
    logic signed [WIDE_W-1:0]    w_diff, o_sum;
    logic                        out_free;

    // ------------------------------------------------------------------
    // helpers

    function automatic logic [CFG_W-1:0] f_coef(input logic [CFG_W-1:0] v);
        return (v > COEF_ONE) ? COEF_ONE : v;
    endfunction

    function automatic logic signed [OPB_W-1:0] f_hi(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] s;
        s = v >>> COEF_FRAC_BITS;
        return s[OPB_W-1:0];
    endfunction

    function automatic logic signed [OPB_W-1:0] f_lo(input logic signed [WIDE_W-1:0] v);
        return $signed({{(OPB_W-COEF_FRAC_BITS){1'b0}}, v[COEF_FRAC_BITS-1:0]});
    endfunction

    function automatic logic signed [SM_W-1:0] f_sat36(input logic signed [WIDE_W-1:0] v);
        if ((&v[WIDE_W-1:SM_W-1]) || !(|v[WIDE_W-1:SM_W-1])) begin
            return v[SM_W-1:0];
        end
        return v[WIDE_W-1] ? {1'b1, {(SM_W-1){1'b0}}} : {1'b0, {(SM_W-1){1'b1}}};
    endfunction

    function automatic logic signed [LP_W-1:0] f_sat32(input logic signed [WIDE_W-1:0] v);
        if ((&v[WIDE_W-1:LP_W-1]) || !(|v[WIDE_W-1:LP_W-1])) begin
            return v[LP_W-1:0];
        end
        return v[WIDE_W-1] ? {1'b1, {(LP_W-1){1'b0}}} : {1'b0, {(LP_W-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] f_sat24(
        input logic signed [WIDE_W-1:0] v);
        if ((&v[WIDE_W-1:SAMPLE_WIDTH-1]) || !(|v[WIDE_W-1:SAMPLE_WIDTH-1])) begin
            return v[SAMPLE_WIDTH-1:0];
        end
        return v[WIDE_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                           : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    endfunction

    // ------------------------------------------------------------------
    // coefficients, clipped to one, and pole terms 2*b0 - one
    assign cs   = f_coef(r_cfg[REG_SMOOTH]);
    assign cl   = f_coef(r_cfg[REG_LOWPASS]);
    assign fb   = f_coef(r_cfg[REG_FEEDBACK]);
    assign wet  = f_coef(r_cfg[REG_WET]);
    assign dry  = COEF_ONE - wet;
    assign as_w = $signed({1'b0, cs, 1'b0}) - $signed({2'b0, COEF_ONE});
    assign al_w = $signed({1'b0, cl, 1'b0}) - $signed({2'b0, COEF_ONE});
    assign as_s = as_w[OPA_W-1:0];
    assign al_s = al_w[OPA_W-1:0];

    assign d_cur = r_cfg[REG_TAP1 + {1'b0, r_tap}];

    // smoothed delay before the filter update
    assign n_df = 37'(mac_prod) + 37'(r_sm[r_tap]);

    // write-back sample and output sample
    assign w_diff = (WIDE_W'(r_xw) - WIDE_W'(mac_acc)) >>> 2;
    assign n_w    = f_sat24(w_diff);
    assign o_sum  = (WIDE_W'(r_od) + WIDE_W'(mac_acc)) >>> 2;
    assign n_out  = f_sat24(o_sum);

    assign out_free = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // multiplier operand select
    always_comb begin
        mac_ctl.a  = '0;
        mac_ctl.b  = '0;
        mac_ctl.op = ACC_HOLD;
        case (r_state)
            S_T_MULD: begin
                mac_ctl.a = $signed({1'b0, cs});
                mac_ctl.b = $signed({{(OPB_W-CFG_W){1'b0}}, d_cur});
            end
            S_T_Q: begin
                mac_ctl.a = as_s;
                mac_ctl.b = f_hi(WIDE_W'(r_df));
            end
            S_T_R: begin
                mac_ctl.a  = as_s;
                mac_ctl.b  = f_lo(WIDE_W'(r_df));
                mac_ctl.op = ACC_LOAD;
            end
            S_L_Q: begin
                mac_ctl.a = $signed({1'b0, cl});
                mac_ctl.b = f_hi(WIDE_W'(r_sum));
            end
            S_L_R: begin
                mac_ctl.a  = $signed({1'b0, cl});
                mac_ctl.b  = f_lo(WIDE_W'(r_sum));
                mac_ctl.op = ACC_LOAD;
            end
            S_L2_Q: begin
                mac_ctl.a = al_s;
                mac_ctl.b = f_hi(WIDE_W'(r_yf));
            end
            S_L2_R: begin
                mac_ctl.a  = al_s;
                mac_ctl.b  = f_lo(WIDE_W'(r_yf));
                mac_ctl.op = ACC_LOAD;
            end
            S_F_Q: begin
                mac_ctl.a = $signed({1'b0, fb});
                mac_ctl.b = f_hi(WIDE_W'(r_yf));
            end
            S_F_R: begin
                mac_ctl.a  = $signed({1'b0, fb});
                mac_ctl.b  = f_lo(WIDE_W'(r_yf));
                mac_ctl.op = ACC_LOAD;
            end
            S_O_Q: begin
                mac_ctl.a = $signed({1'b0, dry});
                mac_ctl.b = f_hi(WIDE_W'(r_xw));
            end
            S_O_R: begin
                mac_ctl.a  = $signed({1'b0, dry});
                mac_ctl.b  = f_lo(WIDE_W'(r_xw));
                mac_ctl.op = ACC_LOAD;
            end
            S_O2_Q: begin
                mac_ctl.a = $signed({1'b0, wet});
                mac_ctl.b = f_hi(WIDE_W'(r_yf));
            end
            S_O2_R: begin
                mac_ctl.a  = $signed({1'b0, wet});
                mac_ctl.b  = f_lo(WIDE_W'(r_yf));
                mac_ctl.op = ACC_LOAD;
            end
            S_T_ADD, S_L_ADD, S_L2_ADD, S_F_ADD, S_O_ADD, S_O2_ADD: begin
                mac_ctl.op = ACC_ADDLO;
            end
            default: begin
                mac_ctl.op = ACC_HOLD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // delay RAM access: clearing pass, tap reads, feedback write
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = n_w;
        ram_re    = 1'b0;
        ram_raddr = r_wp + r_df[COEF_FRAC_BITS +: AW] + AW'(1);
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_T_Q: begin
                ram_re = 1'b1;
            end
            S_F_WR: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer, state registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_wp        <= '1;
            r_tap       <= '0;
            r_lp        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TAPS; i++) begin
                r_sm[i] <= '0;
            end
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else begin
            // config beat
            if (i_cfg_valid) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
            // output register: loaded on the final step, cleared when taken
            if (r_state == S_O_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_xw    <= $signed({i_in_sample, 2'b00});
                        r_sum   <= '0;
                        r_tap   <= '0;
                        r_state <= S_T_MULD;
                    end
                end
                S_T_MULD: r_state <= S_T_DF;
                S_T_DF: begin
                    r_csd   <= mac_prod[34:0];
                    r_df    <= n_df;
                    r_state <= S_T_Q;
                end
                S_T_Q: r_state <= S_T_R;
                S_T_R: begin
                    if (d_cur != '0) begin
                        r_sum <= r_sum + (SAMPLE_WIDTH+3)'($signed(ram_rdata));
                    end
                    r_state <= S_T_ADD;
                end
                S_T_ADD: r_state <= S_T_UPD;
                S_T_UPD: begin
                    r_sm[r_tap] <= f_sat36(WIDE_W'(r_csd) - WIDE_W'(mac_acc));
                    r_tap       <= r_tap + TAP_IDX_W'(1);
                    r_state     <= (&r_tap) ? S_L_Q : S_T_MULD;
                end
                S_L_Q:   r_state <= S_L_R;
                S_L_R:   r_state <= S_L_ADD;
                S_L_ADD: r_state <= S_L_YF;
                S_L_YF: begin
                    r_m1    <= mac_acc[27:0];
                    r_yf    <= 34'(mac_acc) + 34'(r_lp);
                    r_state <= S_L2_Q;
                end
                S_L2_Q:   r_state <= S_L2_R;
                S_L2_R:   r_state <= S_L2_ADD;
                S_L2_ADD: r_state <= S_L_UPD;
                S_L_UPD: begin
                    r_lp    <= f_sat32(WIDE_W'(r_m1) - WIDE_W'(mac_acc));
                    r_state <= S_F_Q;
                end
                S_F_Q:   r_state <= S_F_R;
                S_F_R:   r_state <= S_F_ADD;
                S_F_ADD: r_state <= S_F_WR;
                S_F_WR:  r_state <= S_O_Q;
                S_O_Q:   r_state <= S_O_R;
                S_O_R:   r_state <= S_O_ADD;
                S_O_ADD: r_state <= S_O2_Q;
                S_O2_Q: begin
                    r_od    <= mac_acc;
                    r_state <= S_O2_R;
                end
                S_O2_R:   r_state <= S_O2_ADD;
                S_O2_ADD: r_state <= S_O_OUT;
                S_O_OUT: begin
                    if (out_free) begin
                        r_out_sample <= n_out;
                        r_wp         <= r_wp - AW'(1);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // submodules
    mfd_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .o_prod (mac_prod),
        .o_acc  (mac_acc)
    );

    mfd_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

endmodule

// ===== tb/tb_multitap_feedback_delay.sv =====
// ----------------------------------------------------------------------------
// tb_multitap_feedback_delay
// Self-checking bench for the multitap feedback delay. A bit-exact predictor
// tracks delay memory, tap smoothing and lowpass state per accepted sample;
// every output beat is compared with the oldest predicted sample. Directed
// tests cover sample extremes, saturated coefficients, wrapped and negative
// tap addresses, then random settings with random idling, an output hold-off and random settings without idling.
// ----------------------------------------------------------------------------
module tb_multitap_feedback_delay;
    import mfd_pkg::*;

    localparam int DEPTH      = 131072;
    localparam int DRAIN_WAIT = 60;
    localparam int WD_LIMIT   = 600000;
    localparam int LONG_HOLD  = 300;
    localparam longint ONE    = 65536;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    t_reg_idx                       i_cfg_index = REG_TAP1;
    t_cfg_word                      i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic signed [SAMPLE_WIDTH-1:0] i_in_sample = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] o_out_sample;

    multitap_feedback_delay #(.BUFFER_DEPTH(DEPTH)) DUT (.*);

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    t_cfg_word                      cfg_shadow [NUM_REGS];
    logic signed [SAMPLE_WIDTH-1:0] echo_mem [DEPTH];
    int unsigned                    wr_ptr;
    longint                         tap_smooth [NUM_TAPS];
    longint                         lp_state;

    logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
    int  n_errors  = 0;
    int  n_sent    = 0;
    int  n_checked = 0;
    int  n_cfg     = 0;
    bit  idle_en   = 1'b0;
    bit  hold_req  = 1'b0;

    function automatic longint clip(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    // floor(a * s / 2^16)
    function automatic longint scale16(longint a, longint s);
        longint q;
        longint r;
        q = s >>> COEF_FRAC_BITS;
        r = s - q * ONE;
        return a * q + ((a * r) >>> COEF_FRAC_BITS);
    endfunction

    function automatic longint gain(t_reg_idx i);
        longint c;
        c = longint'(cfg_shadow[i]);
        return c > ONE ? ONE : c;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] mix_sample(
        logic signed [SAMPLE_WIDTH-1:0] x);
        longint xw, cs, as_, cl, al, fb, wet, dry, sum, d, df, k, yf, w, o, addr;
        xw  = longint'(x) * 4;
        cs  = gain(REG_SMOOTH);
        as_ = 2 * cs - ONE;
        cl  = gain(REG_LOWPASS);
        al  = 2 * cl - ONE;
        fb  = gain(REG_FEEDBACK);
        wet = gain(REG_WET);
        dry = ONE - wet;
        sum = 0;
        for (int t = 0; t < NUM_TAPS; t++) begin
            d  = longint'(cfg_shadow[t]);
            df = cs * d + tap_smooth[t];
            k  = df >>> COEF_FRAC_BITS;
            tap_smooth[t] = clip(cs * d - scale16(as_, df), SM_W);
            if (d != 0) begin
                addr = (longint'(wr_ptr) + k + 1) & (DEPTH - 1);
                sum += longint'(echo_mem[addr]);
            end
        end
        yf = scale16(cl, sum) + lp_state;
        lp_state = clip(scale16(cl, sum) - scale16(al, yf), LP_W);
        w = clip((xw - scale16(fb, yf)) >>> 2, SAMPLE_WIDTH);
        echo_mem[wr_ptr] = w[SAMPLE_WIDTH-1:0];
        o = clip((scale16(dry, xw) + scale16(wet, yf)) >>> 2, SAMPLE_WIDTH);
        wr_ptr = (wr_ptr == 0) ? DEPTH - 1 : wr_ptr - 1;
        return o[SAMPLE_WIDTH-1:0];
    endfunction

    // send one input beat, with an optional random gap first
    task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] x);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_sample <= x;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        expected_samples.push_back(mix_sample(x));
        n_sent++;
    endtask

    task automatic write_reg(t_reg_idx idx, t_cfg_word data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        cfg_shadow[idx] = data;
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every predicted beat, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return SAMPLE_WIDTH'($signed($urandom_range(0, 2047)) - 1024);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic t_cfg_word rand_tap();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'($urandom);
            2:       return CFG_W'($urandom_range(1, 3000));
            default: return CFG_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic t_cfg_word rand_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return COEF_ONE;
            2:       return CFG_W'($urandom_range(65537, 131071));
            default: return CFG_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        send_sample(24'sh000000);
        send_sample(24'shFFFFFF);
        send_sample(24'sh000001);
        drain();
    endtask

    task automatic test_short_taps_full_gain();
        write_reg(REG_TAP1, 17'd1);
        write_reg(REG_TAP2, 17'd2);
        write_reg(REG_TAP3, 17'd3);
        write_reg(REG_TAP4, 17'd4);
        write_reg(REG_FEEDBACK, COEF_ONE);
        write_reg(REG_LOWPASS, COEF_ONE);
        write_reg(REG_SMOOTH, COEF_ONE);
        write_reg(REG_WET, COEF_ONE);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? 24'sh800000 : 24'sh7FFFFF);
        drain();
    endtask

    // coefficients above one, tap at the write address, wrapped tap address
    task automatic test_saturated_and_wrap();
        write_reg(REG_TAP1, 17'd131071);
        write_reg(REG_TAP2, 17'd131070);
        write_reg(REG_TAP3, 17'd1);
        write_reg(REG_TAP4, 17'd0);
        write_reg(REG_FEEDBACK, 17'd131071);
        write_reg(REG_LOWPASS, 17'd131071);
        write_reg(REG_SMOOTH, 17'd131071);
        write_reg(REG_WET, 17'd0);
        for (int i = 0; i < 5; i++) send_sample(SAMPLE_WIDTH'(24'sh7FFFFF - i));
        drain();
    endtask

    // slow smoothing builds state, then a full-gain step drives it negative
    task automatic test_negative_smoothing();
        write_reg(REG_TAP1, 17'd100);
        write_reg(REG_TAP2, 17'd131070);
        write_reg(REG_TAP3, 17'd7);
        write_reg(REG_TAP4, 17'd50);
        write_reg(REG_SMOOTH, 17'd1);
        write_reg(REG_WET, 17'd32768);
        for (int i = 0; i < 4; i++) send_sample(rand_sample());
        drain();
        write_reg(REG_SMOOTH, COEF_ONE);
        write_reg(REG_TAP2, 17'd1);
        for (int i = 0; i < 5; i++) send_sample(rand_sample());
        drain();
    endtask

    task automatic test_random_settings(int phases, int per_phase, bit idle);
        idle_en = idle;
        for (int p = 0; p < phases; p++) begin
            write_reg(REG_TAP1, rand_tap());
            write_reg(REG_TAP2, rand_tap());
            write_reg(REG_TAP3, rand_tap());
            write_reg(REG_TAP4, rand_tap());
            write_reg(REG_FEEDBACK, rand_coef());
            write_reg(REG_LOWPASS, rand_coef());
            write_reg(REG_SMOOTH, $urandom_range(0, 2) == 0 ? rand_coef() : COEF_ONE);
            write_reg(REG_WET, rand_coef());
            for (int i = 0; i < per_phase; i++) send_sample(rand_sample());
            drain();
        end
    endtask

    // receiver holds off while beats keep coming, so the input stalls
    task automatic test_output_backpressure();
        idle_en  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) send_sample(rand_sample());
        drain();
    endtask

    // receiver idling and long hold-off
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // output beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                $error("out_sample: unexpected beat, actual %0d", o_out_sample);
                n_errors++;
            end else begin
                if (o_out_sample !== expected_samples[0]) begin
                    $error("out_sample: expected %0d, actual %0d",
                           expected_samples[0], o_out_sample);
                    n_errors++;
                end
                void'(expected_samples.pop_front());
                n_checked++;
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog expired, %0d beats still expected", expected_samples.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_REGS; i++) cfg_shadow[i] = CFG_RESET[i];
        for (int i = 0; i < DEPTH; i++) echo_mem[i] = '0;
        for (int t = 0; t < NUM_TAPS; t++) tap_smooth[t] = 0;
        lp_state = 0;
        wr_ptr   = DEPTH - 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_short_taps_full_gain();
        test_saturated_and_wrap();
        test_negative_smoothing();
        test_random_settings(8, 60, 1'b1);
        test_output_backpressure();
        test_random_settings(2, 60, 1'b0);

        $display("covered %0d samples and %0d register writes, %0d output beats checked",
                 n_sent, n_cfg, n_checked);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
